// File: rtl/tpij_pkg.sv
// ----------------------------------------------------------------------------
// tpij_pkg
// Types and constants for the two-point image Jacobian pipeline.
// ----------------------------------------------------------------------------
package tpij_pkg;

	localparam int NUM_LANES = 5;
	localparam int DIV_STEPS = 33;

	localparam int FLDW = 32;
	localparam int OPW  = FLDW + 1;
	localparam int PRODW = 2 * OPW;
	localparam int SUMW = PRODW + 1;
	localparam int MAGW = 2 * FLDW;
	localparam int PARTW = MAGW;
	localparam int NUMW = MAGW + FLDW;
	localparam int ZW   = FLDW - 1;
	localparam int DENW = 2 * ZW;
	localparam int QUOW = DIV_STEPS;

	localparam logic [63:0] FOCAL_E4  = 64'd36296187;
	localparam logic [63:0] FOCAL_DIV = 64'd10000;
	localparam logic [63:0] FOCAL_MAX = 64'h0000_0000_FFFF_FFFF;

	localparam logic signed [FLDW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [FLDW-1:0] SAT_MIN = 32'sh8000_0000;

	localparam int LANE_LIN = 0;
	localparam int LANE_VZ  = 1;
	localparam int LANE_WX  = 2;
	localparam int LANE_WY  = 3;
	localparam int LANE_WZ  = 4;

	localparam logic [1:0] LAST_ROW = 2'd3;

	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_OFFSET_Y = 3'd3,
		REG_OFFSET_Z = 3'd4
	} reg_index_t;

	typedef logic signed [OPW-1:0] opnd_t;

	typedef struct packed {
		opnd_t a1;
		opnd_t b1;
		opnd_t a2;
		opnd_t b2;
	} lane_ops_t;

	typedef struct packed {
		logic [1:0] row;
		logic       bad;
		logic       last;
	} row_tag_t;

endpackage

// File: rtl/two_point_image_jacobian.sv
// ----------------------------------------------------------------------------
// two_point_image_jacobian
// Image Jacobian J*M*Q of two point features, one row of six entries a cycle unless stalled.
// ----------------------------------------------------------------------------
// One item (two camera-frame points) yields four result rows; the rows share a
// single row datapath of five entry lanes; a new item is taken as the held
// one's last row enters, and rows leave one per cycle unless stalled. A row
// spends 40 register stages in flight: six for operand select, products, sum,
// magnitude and focal scaling, 33 for the one-bit-per-stage restoring divide
// by depth squared, one output register. Stalls collapse bubbles stage by stage.
module two_point_image_jacobian
	import tpij_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr,
	input  logic [REG_IDX_W-1:0]         cfg_index,
	input  logic [FLDW-1:0]              cfg_data,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [FLDW-1:0]       first_x,
	input  logic signed [FLDW-1:0]       first_y,
	input  logic signed [FLDW-1:0]       first_depth,
	input  logic signed [FLDW-1:0]       second_x,
	input  logic signed [FLDW-1:0]       second_y,
	input  logic signed [FLDW-1:0]       second_depth,
	output logic                         row_valid,
	input  logic                         row_stall,
	output logic [1:0]                   row_index,
	output logic signed [FLDW-1:0]       col_vx,
	output logic signed [FLDW-1:0]       col_vy,
	output logic signed [FLDW-1:0]       col_vz,
	output logic signed [FLDW-1:0]       col_wx,
	output logic signed [FLDW-1:0]       col_wy,
	output logic signed [FLDW-1:0]       col_wz,
	output logic                         bad_depth,
	output logic                         last_row
);

	localparam logic [63:0] FOCAL_FULL = (FOCAL_E4 << FRAC_BITS) / FOCAL_DIV;
	localparam logic [FLDW-1:0] FOCAL_RESET =
		(FOCAL_FULL > FOCAL_MAX) ? FOCAL_MAX[FLDW-1:0] : FOCAL_FULL[FLDW-1:0];
	localparam opnd_t SCALE = opnd_t'(64'd1 << FRAC_BITS);
	localparam opnd_t NEG_SCALE = -SCALE;

	localparam int ST_DIV0 = 6;
	localparam int NSTG = ST_DIV0 + DIV_STEPS + 1;
	localparam int ST_OUT = NSTG - 1;

	// configuration
	logic [FLDW-1:0]        focal_x_q, focal_y_q;
	logic signed [FLDW-1:0] off_x_q, off_y_q, off_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_RESET;
			focal_y_q <= FOCAL_RESET;
			off_x_q   <= '0;
			off_y_q   <= '0;
			off_z_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FOCAL_X:  focal_x_q <= cfg_data;
				REG_FOCAL_Y:  focal_y_q <= cfg_data;
				REG_OFFSET_X: off_x_q   <= cfg_data;
				REG_OFFSET_Y: off_y_q   <= cfg_data;
				REG_OFFSET_Z: off_z_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage advance chain
	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   ld;

	always_comb begin
		ld[NSTG] = !row_stall;
		for (int k = NSTG - 1; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	// item hold and row sequencer
	logic                   hold_q;
	logic [1:0]             row_q;
	logic signed [FLDW-1:0] fx_q, fy_q, fz_q, sx_q, sy_q, sz_q;
	logic                   take, take_last, item_xfer;

	assign take       = hold_q && ld[0];
	assign take_last  = take && (row_q == LAST_ROW);
	assign item_stall = hold_q && !take_last;
	assign item_xfer  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			row_q  <= '0;
		end else begin
			if (take) begin
				row_q <= row_q + 2'd1;
			end
			if (take_last) begin
				hold_q <= 1'b0;
			end
			if (item_xfer) begin
				hold_q <= 1'b1;
				row_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			fx_q <= first_x;
			fy_q <= first_y;
			fz_q <= first_depth;
			sx_q <= second_x;
			sy_q <= second_y;
			sz_q <= second_depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= (k == 0) ? hold_q : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	// operand select
	logic signed [FLDW-1:0] pt_x, pt_y, pt_z;
	opnd_t                  xs, ys, zs, dx, dy, rzz, zrz;
	logic                   is_v;
	lane_ops_t              ops_in [NUM_LANES];
	row_tag_t               tag_in;

	assign is_v = row_q[0];
	assign pt_x = row_q[1] ? sx_q : fx_q;
	assign pt_y = row_q[1] ? sy_q : fy_q;
	assign pt_z = row_q[1] ? sz_q : fz_q;
	assign xs   = {pt_x[FLDW-1], pt_x};
	assign ys   = {pt_y[FLDW-1], pt_y};
	assign zs   = {pt_z[FLDW-1], pt_z};
	assign dy   = ys - {off_y_q[FLDW-1], off_y_q};
	assign dx   = {off_x_q[FLDW-1], off_x_q} - xs;
	assign rzz  = {off_z_q[FLDW-1], off_z_q} - zs;
	assign zrz  = zs - {off_z_q[FLDW-1], off_z_q};

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			ops_in[l] = '0;
		end
		ops_in[LANE_LIN].a1 = NEG_SCALE;
		ops_in[LANE_LIN].b1 = zs;
		if (!is_v) begin
			ops_in[LANE_VZ].a1 = xs;
			ops_in[LANE_VZ].b1 = SCALE;
			ops_in[LANE_WX].a1 = xs;
			ops_in[LANE_WX].b1 = dy;
			ops_in[LANE_WY].a1 = rzz;
			ops_in[LANE_WY].b1 = zs;
			ops_in[LANE_WY].a2 = xs;
			ops_in[LANE_WY].b2 = dx;
			ops_in[LANE_WZ].a1 = dy;
			ops_in[LANE_WZ].b1 = zs;
		end else begin
			ops_in[LANE_VZ].a1 = ys;
			ops_in[LANE_VZ].b1 = SCALE;
			ops_in[LANE_WX].a1 = zrz;
			ops_in[LANE_WX].b1 = zs;
			ops_in[LANE_WX].a2 = ys;
			ops_in[LANE_WX].b2 = dy;
			ops_in[LANE_WY].a1 = ys;
			ops_in[LANE_WY].b1 = dx;
			ops_in[LANE_WZ].a1 = dx;
			ops_in[LANE_WZ].b1 = zs;
		end
		tag_in.row  = row_q;
		tag_in.bad  = pt_z[FLDW-1] || (pt_z == '0);
		tag_in.last = (row_q == LAST_ROW);
	end

	// s1: operands
	lane_ops_t       ops_s1 [NUM_LANES];
	logic [FLDW-1:0] f_s1;
	logic [ZW-1:0]   z_s1;
	row_tag_t        tag_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			ops_s1 <= ops_in;
			f_s1   <= is_v ? focal_y_q : focal_x_q;
			z_s1   <= pt_z[ZW-1:0];
			tag_s1 <= tag_in;
		end
	end

	// s2: products
	logic signed [PRODW-1:0] p1_s2 [NUM_LANES];
	logic signed [PRODW-1:0] p2_s2 [NUM_LANES];
	logic [FLDW-1:0]         f_s2;
	logic [DENW-1:0]         zz_s2;
	row_tag_t                tag_s2;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				p1_s2[l] <= PRODW'(ops_s1[l].a1) * PRODW'(ops_s1[l].b1);
				p2_s2[l] <= PRODW'(ops_s1[l].a2) * PRODW'(ops_s1[l].b2);
			end
			f_s2   <= f_s1;
			zz_s2  <= DENW'(z_s1) * DENW'(z_s1);
			tag_s2 <= tag_s1;
		end
	end

	// s3: sum
	logic signed [SUMW-1:0] sum_s3 [NUM_LANES];
	logic [FLDW-1:0]        f_s3;
	logic [DENW-1:0]        zz_s3;
	row_tag_t               tag_s3;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				sum_s3[l] <= SUMW'(p1_s2[l]) + SUMW'(p2_s2[l]);
			end
			f_s3   <= f_s2;
			zz_s3  <= zz_s2;
			tag_s3 <= tag_s2;
		end
	end

	// s4: magnitude
	logic [SUMW-1:0]       abs_s3 [NUM_LANES];
	logic [MAGW-1:0]       mag_s4 [NUM_LANES];
	logic [NUM_LANES-1:0]  neg_s4;
	logic [FLDW-1:0]       f_s4;
	logic [DENW-1:0]       zz_s4;
	row_tag_t              tag_s4;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			abs_s3[l] = sum_s3[l][SUMW-1] ? -sum_s3[l] : sum_s3[l];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				mag_s4[l] <= abs_s3[l][MAGW-1:0];
				neg_s4[l] <= sum_s3[l][SUMW-1];
			end
			f_s4   <= f_s3;
			zz_s4  <= zz_s3;
			tag_s4 <= tag_s3;
		end
	end

	// s5: focal scaling, partial products
	logic [PARTW-1:0]     pl_s5 [NUM_LANES];
	logic [PARTW-1:0]     ph_s5 [NUM_LANES];
	logic [NUM_LANES-1:0] neg_s5;
	logic [DENW-1:0]      zz_s5;
	row_tag_t             tag_s5;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				pl_s5[l] <= PARTW'(mag_s4[l][FLDW-1:0]) * PARTW'(f_s4);
				ph_s5[l] <= PARTW'(mag_s4[l][MAGW-1:FLDW]) * PARTW'(f_s4);
			end
			neg_s5 <= neg_s4;
			zz_s5  <= zz_s4;
			tag_s5 <= tag_s4;
		end
	end

	// s6: numerator
	logic [NUMW-1:0]      num_s6 [NUM_LANES];
	logic [NUM_LANES-1:0] neg_s6;
	logic [DENW-1:0]      zz_s6;
	row_tag_t             tag_s6;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				num_s6[l] <= {ph_s5[l], {FLDW{1'b0}}} + NUMW'(pl_s5[l]);
			end
			neg_s6 <= neg_s5;
			zz_s6  <= zz_s5;
			tag_s6 <= tag_s5;
		end
	end

	// restoring divide by depth squared, one quotient bit per stage
	logic [NUMW-1:0]      rem_sd [DIV_STEPS-1][NUM_LANES];
	logic [DENW-1:0]      zz_sd  [DIV_STEPS-1];
	logic [QUOW-1:0]      quo_sd [DIV_STEPS][NUM_LANES];
	logic [NUM_LANES-1:0] neg_sd [DIV_STEPS];
	row_tag_t             tag_sd [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - j;
		logic [NUMW-1:0]      rem_in [NUM_LANES];
		logic [QUOW-1:0]      quo_in [NUM_LANES];
		logic [NUM_LANES-1:0] neg_in;
		logic [DENW-1:0]      zz_in;
		row_tag_t             tag_in_d;
		logic [NUMW-1:0]      den;
		logic [NUM_LANES-1:0] fit;
		logic [NUMW-1:0]      rem_nx [NUM_LANES];

		if (j == 0) begin : g_src
			assign rem_in   = num_s6;
			assign quo_in   = '{default: '0};
			assign neg_in   = neg_s6;
			assign zz_in    = zz_s6;
			assign tag_in_d = tag_s6;
		end else begin : g_src
			assign rem_in   = rem_sd[j-1];
			assign quo_in   = quo_sd[j-1];
			assign neg_in   = neg_sd[j-1];
			assign zz_in    = zz_sd[j-1];
			assign tag_in_d = tag_sd[j-1];
		end

		assign den = NUMW'(zz_in) << SH;

		always_comb begin
			for (int l = 0; l < NUM_LANES; l++) begin
				fit[l]    = (rem_in[l] >= den);
				rem_nx[l] = fit[l] ? (rem_in[l] - den) : rem_in[l];
			end
		end

		always_ff @(posedge clk) begin
			if (ld[ST_DIV0+j]) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					quo_sd[j][l] <= {quo_in[l][QUOW-2:0], fit[l]};
				end
				neg_sd[j] <= neg_in;
				tag_sd[j] <= tag_in_d;
			end
		end

		if (j < DIV_STEPS - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (ld[ST_DIV0+j]) begin
					rem_sd[j] <= rem_nx;
					zz_sd[j]  <= zz_in;
				end
			end
		end
	end

	// saturate, place columns, output register
	logic signed [FLDW-1:0] sat [NUM_LANES];
	logic [QUOW-1:0]        q_fin [NUM_LANES];
	row_tag_t               tag_fin;
	logic                   row_is_v;

	assign q_fin    = quo_sd[DIV_STEPS-1];
	assign tag_fin  = tag_sd[DIV_STEPS-1];
	assign row_is_v = tag_fin.row[0];

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			if (tag_fin.bad) begin
				sat[l] = '0;
			end else if (!neg_sd[DIV_STEPS-1][l]) begin
				sat[l] = (q_fin[l][QUOW-1] || q_fin[l][FLDW-1]) ?
					SAT_MAX : q_fin[l][FLDW-1:0];
			end else begin
				sat[l] = (q_fin[l][QUOW-1] ||
					(q_fin[l][FLDW-1] && (|q_fin[l][FLDW-2:0]))) ?
					SAT_MIN : -q_fin[l][FLDW-1:0];
			end
		end
	end

	logic [1:0]             row_so;
	logic signed [FLDW-1:0] vx_so, vy_so, vz_so, wx_so, wy_so, wz_so;
	logic                   bad_so, last_so;

	always_ff @(posedge clk) begin
		if (ld[ST_OUT]) begin
			row_so  <= tag_fin.row;
			vx_so   <= row_is_v ? '0 : sat[LANE_LIN];
			vy_so   <= row_is_v ? sat[LANE_LIN] : '0;
			vz_so   <= sat[LANE_VZ];
			wx_so   <= sat[LANE_WX];
			wy_so   <= sat[LANE_WY];
			wz_so   <= sat[LANE_WZ];
			bad_so  <= tag_fin.bad;
			last_so <= tag_fin.last;
		end
	end

	assign row_valid = vld_q[ST_OUT];
	assign row_index = row_so;
	assign col_vx    = vx_so;
	assign col_vy    = vy_so;
	assign col_vz    = vz_so;
	assign col_wx    = wx_so;
	assign col_wy    = wy_so;
	assign col_wz    = wz_so;
	assign bad_depth = bad_so;
	assign last_row  = last_so;

endmodule

// File: tb/sv/tpij_checker.sv
// ----------------------------------------------------------------------------
// tpij_checker
// Watches the item, row and register ports of the two-point image Jacobian,
// predicts the four rows of each accepted item and compares them in order.
// ----------------------------------------------------------------------------
module tpij_checker
	import tpij_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [FLDW-1:0]        cfg_data,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  logic signed [FLDW-1:0] first_x,
	input  logic signed [FLDW-1:0] first_y,
	input  logic signed [FLDW-1:0] first_depth,
	input  logic signed [FLDW-1:0] second_x,
	input  logic signed [FLDW-1:0] second_y,
	input  logic signed [FLDW-1:0] second_depth,
	input  logic                   row_valid,
	input  logic                   row_stall,
	input  logic [1:0]             row_index,
	input  logic signed [FLDW-1:0] col_vx,
	input  logic signed [FLDW-1:0] col_vy,
	input  logic signed [FLDW-1:0] col_vz,
	input  logic signed [FLDW-1:0] col_wx,
	input  logic signed [FLDW-1:0] col_wy,
	input  logic signed [FLDW-1:0] col_wz,
	input  logic                   bad_depth,
	input  logic                   last_row,
	output int                     errors,
	output int                     pending
);

	localparam logic [31:0] FOCAL_RESET = 32'd237870691;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0]  row;
		logic [31:0] col [6];
		logic        bad;
		logic        last;
	} jac_row_t;

	jac_row_t expected_rows [$];
	logic [31:0] focal_x_q, focal_y_q;
	logic signed [31:0] off_x_q, off_y_q, off_z_q;

	function automatic logic [31:0] jac_entry(wide_t num, wide_t z);
		wide_t q;
		q = num / (z * z);
		if (q > wide_t'(32'sh7FFF_FFFF))
			return SAT_MAX;
		if (q < -wide_t'(64'sh8000_0000))
			return SAT_MIN;
		return q[31:0];
	endfunction

	task automatic predict_point(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz, logic [1:0] row0);
		jac_row_t u, v;
		wide_t x, y, z, fx, fy, rx, ry, rz, s;
		x = px; y = py; z = pz;
		rx = off_x_q; ry = off_y_q; rz = off_z_q;
		fx = {96'd0, focal_x_q};
		fy = {96'd0, focal_y_q};
		s = wide_t'(1) <<< 16;
		u.row = row0;
		v.row = row0 + 2'd1;
		u.last = 1'b0;
		v.last = (v.row == LAST_ROW);
		u.bad = (pz <= 0);
		v.bad = u.bad;
		for (int i = 0; i < 6; i++) begin
			u.col[i] = '0;
			v.col[i] = '0;
		end
		if (pz > 0) begin
			u.col[0] = jac_entry(-fx * s * z, z);
			u.col[2] = jac_entry(fx * x * s, z);
			u.col[3] = jac_entry(fx * x * (y - ry), z);
			u.col[4] = jac_entry(fx * ((rz - z) * z + x * (rx - x)), z);
			u.col[5] = jac_entry(fx * (y - ry) * z, z);
			v.col[1] = jac_entry(-fy * s * z, z);
			v.col[2] = jac_entry(fy * y * s, z);
			v.col[3] = jac_entry(fy * ((z - rz) * z + y * (y - ry)), z);
			v.col[4] = jac_entry(fy * y * (rx - x), z);
			v.col[5] = jac_entry(fy * (rx - x) * z, z);
		end
		expected_rows.push_back(u);
		expected_rows.push_back(v);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic check_row();
		jac_row_t e;
		logic [31:0] got [6];
		got = '{col_vx, col_vy, col_vz, col_wx, col_wy, col_wz};
		if (expected_rows.size() == 0) begin
			report("unexpected row", {30'd0, row_index}, 32'd0);
			return;
		end
		e = expected_rows.pop_front();
		if (row_index !== e.row)
			report("row_index", {30'd0, row_index}, {30'd0, e.row});
		for (int i = 0; i < 6; i++)
			if (got[i] !== e.col[i])
				report($sformatf("row %0d col %0d", e.row, i), got[i], e.col[i]);
		if (bad_depth !== e.bad)
			report("bad_depth", {31'd0, bad_depth}, {31'd0, e.bad});
		if (last_row !== e.last)
			report("last_row", {31'd0, last_row}, {31'd0, e.last});
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q = FOCAL_RESET;
			focal_y_q = FOCAL_RESET;
			off_x_q = '0;
			off_y_q = '0;
			off_z_q = '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_FOCAL_X:  focal_x_q = cfg_data;
					REG_FOCAL_Y:  focal_y_q = cfg_data;
					REG_OFFSET_X: off_x_q = cfg_data;
					REG_OFFSET_Y: off_y_q = cfg_data;
					REG_OFFSET_Z: off_z_q = cfg_data;
					default: ;
				endcase
			end
			if (row_valid && !row_stall)
				check_row();
			if (item_valid && !item_stall) begin
				predict_point(first_x, first_y, first_depth, 2'd0);
				predict_point(second_x, second_y, second_depth, 2'd2);
			end
			pending = expected_rows.size();
		end
	end

endmodule

// File: tb/sv/tb_two_point_image_jacobian.sv
// ----------------------------------------------------------------------------
// tb_two_point_image_jacobian
// Drives point pairs and register settings into the two-point image Jacobian
// with random gaps and stalls on both channels; the checker predicts every
// row and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_two_point_image_jacobian;
	import tpij_pkg::*;

	logic clk, arst_n;
	logic cfg_wr;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [FLDW-1:0] cfg_data;
	logic item_valid, item_stall;
	logic signed [FLDW-1:0] first_x, first_y, first_depth;
	logic signed [FLDW-1:0] second_x, second_y, second_depth;
	logic row_valid, row_stall;
	logic [1:0] row_index;
	logic signed [FLDW-1:0] col_vx, col_vy, col_vz, col_wx, col_wy, col_wz;
	logic bad_depth, last_row;
	int errors, pending;
	bit send_idle, recv_idle;

	two_point_image_jacobian uut (.*);
	tpij_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_points(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
		logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
		int gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		first_x <= ax; first_y <= ay; first_depth <= az;
		second_x <= bx; second_y <= by; second_depth <= bz;
		do @(posedge clk); while (item_stall);
	endtask

	function automatic logic [31:0] coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
		endcase
	endfunction

	function automatic logic [31:0] depth();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $signed(0) - $signed($urandom_range(0, 3));
			2: return $urandom_range(1, 64);
			default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
		endcase
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0) send_idle = $urandom_range(0, 3) != 0;
			send_points(coord(), coord(), depth(), coord(), coord(), depth());
		end
		item_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		row_stall = 1'b1;
		recv_idle = 1'b1;
		@(posedge arst_n);
		forever begin
			int w;
			w = recv_idle ? $urandom_range(0, 12) : 0;
			if (w > 0) begin
				row_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			row_stall <= 1'b0;
			do @(posedge clk); while (!row_valid);
			if ($urandom_range(0, 40) == 0) recv_idle = !recv_idle;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		{first_x, first_y, first_depth, second_x, second_y, second_depth} = '0;
		send_idle = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings
		send_points(0, 0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
		send_points(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF);
		send_points(32'h0000_8000, 32'h0000_4000, 0, 32'h0000_8000, 32'h0000_4000,
			32'h8000_0000);
		send_points(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0003_0000, 5, 1);
		send_points(32'h0000_1000, 32'hFFFF_F000, 32'h0000_8000, 32'h1234_5678,
			32'hEDCB_A988, 32'h0010_0000);
		item_valid <= 1'b0;
		drain();

		// extremes of focal and offsets
		write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
		write_reg(REG_FOCAL_Y, 32'd0);
		write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
		write_reg(REG_OFFSET_Y, 32'h8000_0000);
		write_reg(REG_OFFSET_Z, 32'h7FFF_FFFF);
		write_reg(REG_IDX_W'(REG_OFFSET_Z + 1), 32'hDEAD_BEEF);
		send_points(0, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_points(32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0000_8000, 32'h0000_4000,
			32'h0002_0000);
		random_items(15);
		drain();

		write_reg(REG_FOCAL_X, 32'd0);
		write_reg(REG_FOCAL_Y, 32'hFFFF_FFFF);
		write_reg(REG_OFFSET_X, 32'h8000_0000);
		write_reg(REG_OFFSET_Y, 32'h7FFF_FFFF);
		write_reg(REG_OFFSET_Z, 32'h8000_0000);
		write_reg(3'd7, 32'h0000_0001);
		send_points(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1);
		random_items(15);
		drain();

		// random settings
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_FOCAL_X, $urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(32'h0010_0000, 32'h1000_0000));
			write_reg(REG_FOCAL_Y, $urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(32'h0010_0000, 32'h1000_0000));
			write_reg(REG_OFFSET_X, coord());
			write_reg(REG_OFFSET_Y, coord());
			write_reg(REG_OFFSET_Z, coord());
			random_items(44);
			drain();
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
